// ----- hdl/phmb_pkg.sv -----
// Package for the peak hold meter bank: field widths, register indexes,
// reset values and the per-channel store entry. No dependencies.

package phmb_pkg;

    localparam int CHANNEL_W = 6;
    localparam int LEVEL_W   = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CH_SPAN   = 1 << CHANNEL_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_RATE   = 2'd2;

    // Register reset values: -100 dB floor, 1 s hold, 24 dB/s fall
    localparam logic signed [LEVEL_W-1:0] FLOOR_RESET = -16'sd25600;
    localparam logic [CFG_W-1:0]          HOLD_RESET  = 16'd1024;
    localparam logic [CFG_W-1:0]          RATE_RESET  = 16'd6144;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] shown;
        logic [TIME_W-1:0]         peak_time;
        logic [TIME_W-1:0]         adv_time;
    } t_meter_entry;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] floor_level;
        logic [CFG_W-1:0]          hold_ticks;
        logic [CFG_W-1:0]          fall_rate;
    } t_meter_cfg;

    localparam t_meter_entry ENTRY_RESET = '{
        shown:     FLOOR_RESET,
        peak_time: '0,
        adv_time:  '0
    };

endpackage

// ----- hdl/phmb_in_if.sv -----
// Request channel of the peak hold meter bank: valid/ready plus payload.
// Depends on phmb_pkg for field widths.

interface phmb_in_if import phmb_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [CHANNEL_W-1:0]      channel;
    logic signed [LEVEL_W-1:0] peak_level;
    logic [TIME_W-1:0]         now_ticks;

    modport source (output valid, func, channel, peak_level, now_ticks, input ready);
    modport sink   (input valid, func, channel, peak_level, now_ticks, output ready);
endinterface

// ----- hdl/phmb_out_if.sv -----
// Result channel of the peak hold meter bank: valid/ready plus payload.
// Depends on phmb_pkg for field widths.

interface phmb_out_if import phmb_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [CHANNEL_W-1:0]      out_channel;
    logic signed [LEVEL_W-1:0] shown_level;

    modport source (output valid, out_channel, shown_level, input ready);
    modport sink   (input valid, out_channel, shown_level, output ready);
endinterface

// ----- hdl/phmb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module phmb_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/phmb_update.sv -----
// Per-channel meter update: peak capture, hold expiry and linear fall.
// Depends on phmb_pkg for the entry and configuration structs.

module phmb_update import phmb_pkg::*; (
    input  t_meter_entry              i_entry,
    input  t_meter_cfg                i_cfg,
    input  logic                      i_func,
    input  logic signed [LEVEL_W-1:0] i_peak_level,
    input  logic [TIME_W-1:0]         i_now_ticks,
    output t_meter_entry              o_entry
);

    localparam int PROD_W = CFG_W + TIME_W;
    localparam int DROP_W = PROD_W - 10;
    localparam int DIFF_W = DROP_W + 2;

    logic                      peak_gt;
    logic signed [LEVEL_W-1:0] level_peak;
    logic [TIME_W-1:0]         peak_time;
    logic [TIME_W:0]           hold_end;
    logic [TIME_W:0]           adv_ext;
    logic [TIME_W:0]           fall_start;
    logic                      falls;
    logic [TIME_W-1:0]         dt;
    logic [PROD_W-1:0]         prod;
    logic [DROP_W-1:0]         drop;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  floor_ext;
    logic signed [LEVEL_W-1:0] level_fallen;

    always_comb begin
        // capture a strictly louder peak and restart the hold
        peak_gt    = i_peak_level > i_entry.shown;
        level_peak = peak_gt ? i_peak_level : i_entry.shown;
        peak_time  = peak_gt ? i_now_ticks : i_entry.peak_time;

        // fall starts at the later of the last update and the end of the hold
        hold_end   = {1'b0, peak_time} + {{(TIME_W + 1 - CFG_W){1'b0}}, i_cfg.hold_ticks};
        adv_ext    = {1'b0, i_entry.adv_time};
        fall_start = (adv_ext > hold_end) ? adv_ext : hold_end;
        falls      = i_func && ({1'b0, i_now_ticks} > fall_start);

        dt   = i_now_ticks - fall_start[TIME_W-1:0];
        prod = PROD_W'(i_cfg.fall_rate) * PROD_W'(dt);
        drop = prod[PROD_W-1:10];

        // saturate at the floor
        diff      = DIFF_W'(level_peak) - $signed({2'b00, drop});
        floor_ext = DIFF_W'(i_cfg.floor_level);
        level_fallen = (diff < floor_ext) ? i_cfg.floor_level : diff[LEVEL_W-1:0];

        o_entry.shown     = falls ? level_fallen : level_peak;
        o_entry.peak_time = peak_time;
        o_entry.adv_time  = i_now_ticks;
    end

endmodule

// ----- hdl/peak_hold_meter_bank_top.sv -----
// Top level of the peak hold meter bank: request/result pipeline, meter store,
// configuration registers. Depends on phmb_pkg, phmb_in_if, phmb_out_if,
// phmb_ram and phmb_update.
//
// Usage:
//   i_req carries one request per handshake: func (0 observe, 1 sample),
//   channel, peak_level (1/256 dB) and now_ticks (1/1024 s). o_rsp returns one
//   result per request, in order: out_channel and the channel's shown_level.
//   The configuration port (i_cfg_wr_en, i_cfg_index, i_cfg_data) sets
//   floor_level, hold_ticks and fall_rate; write it only while no request is
//   in flight. Unknown indexes are dropped.
// Timing:
//   A request is registered into the update stage, its result into the result
//   register. One request is accepted every cycle while o_rsp is not stalled:
//   the store read is issued at acceptance, the update runs in the following
//   cycle and the result register decouples the receiver. A same-channel write
//   by the request just ahead is forwarded, so back-to-back hits cost nothing.
// Reset:
//   Every channel reads as -100 dB with zero times; a valid flag per channel
//   stands in for a clearing pass, so requests are taken right after reset.
// Stall:
//   When o_rsp.ready is low, the result holds, the update stage fills, then
//   i_req.ready drops until the receiver takes the result.

module peak_hold_meter_bank_top import phmb_pkg::*; #(
    parameter int CHANNELS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    phmb_in_if.sink              i_req,
    phmb_out_if.source           o_rsp,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // only channel codes that fit the channel field get storage
    localparam int DEPTH    = (CHANNELS < CH_SPAN) ? CHANNELS : CH_SPAN;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIMIT_W  = 11;
    localparam logic [LIMIT_W-1:0] CH_LIMIT = LIMIT_W'(CHANNELS);

    // configuration
    t_meter_cfg r_cfg;

    // update stage
    logic                      r_s1_valid;
    logic                      r_s1_func;
    logic [CHANNEL_W-1:0]      r_s1_channel;
    logic signed [LEVEL_W-1:0] r_s1_peak;
    logic [TIME_W-1:0]         r_s1_now;
    logic                      r_s1_hit;
    logic                      r_s1_stored;

    // result stage
    logic                      r_out_valid;
    logic [CHANNEL_W-1:0]      r_out_channel;
    logic signed [LEVEL_W-1:0] r_out_level;

    // store bookkeeping
    logic [DEPTH-1:0]          r_entry_valid;
    t_meter_entry              r_wr_entry;

    logic                      req_accept;
    logic                      s1_fire;
    logic                      s1_in_range;
    logic                      wr_en;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             wr_addr;
    logic [$bits(t_meter_entry)-1:0] ram_q;
    t_meter_entry              cur_entry;
    t_meter_entry              upd_entry;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_level <= FLOOR_RESET;
            r_cfg.hold_ticks  <= HOLD_RESET;
            r_cfg.fall_rate   <= RATE_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FLOOR_LEVEL: r_cfg.floor_level <= $signed(i_cfg_data);
                CFG_HOLD_TICKS:  r_cfg.hold_ticks  <= i_cfg_data;
                CFG_FALL_RATE:   r_cfg.fall_rate   <= i_cfg_data;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: advance the update stage when the result slot frees up
    // ---------------------------------------------------------------
    assign s1_fire     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_fire;
    assign req_accept  = i_req.valid && i_req.ready;

    assign s1_in_range = {{(LIMIT_W - CHANNEL_W){1'b0}}, r_s1_channel} < CH_LIMIT;
    assign wr_en       = s1_fire && s1_in_range;
    assign wr_addr     = r_s1_channel[AW-1:0];
    assign rd_addr     = i_req.channel[AW-1:0];

    // ---------------------------------------------------------------
    // Meter store: shown level, peak time and last update time per channel
    // ---------------------------------------------------------------
    phmb_ram #(
        .WIDTH ($bits(t_meter_entry)),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (upd_entry),
        .i_rd_en   (req_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    // A channel never written reads as its reset entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (wr_en) begin
            r_entry_valid[wr_addr] <= 1'b1;
        end
    end

    // Hold the last write for forwarding; it stays put while the next
    // request waits in the update stage, since nothing else writes.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wr_entry <= upd_entry;
        end
    end

    // ---------------------------------------------------------------
    // Update stage register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_s1_func    <= i_req.func;
            r_s1_channel <= i_req.channel;
            r_s1_peak    <= i_req.peak_level;
            r_s1_now     <= i_req.now_ticks;
            // the store read at this edge misses a write at the same edge
            r_s1_hit     <= wr_en && (r_s1_channel == i_req.channel);
            r_s1_stored  <= r_entry_valid[rd_addr];
        end
    end

    always_comb begin
        if (r_s1_hit) begin
            cur_entry = r_wr_entry;
        end else if (r_s1_stored) begin
            cur_entry = t_meter_entry'(ram_q);
        end else begin
            cur_entry = ENTRY_RESET;
        end
    end

    phmb_update u_update (
        .i_entry      (cur_entry),
        .i_cfg        (r_cfg),
        .i_func       (r_s1_func),
        .i_peak_level (r_s1_peak),
        .i_now_ticks  (r_s1_now),
        .o_entry      (upd_entry)
    );

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_channel <= r_s1_channel;
            // an unmapped channel reports the floor and leaves the store alone
            r_out_level   <= s1_in_range ? upd_entry.shown : r_cfg.floor_level;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.out_channel = r_out_channel;
    assign o_rsp.shown_level = r_out_level;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_write_unmapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> s1_in_range && r_s1_valid)
        else $error("store written for an unmapped channel");

    a_forward_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_accept && wr_en && (r_s1_channel == i_req.channel)) |=> r_s1_hit)
        else $error("same-channel write at acceptance not marked for forwarding");

    a_stall_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("request taken while the update stage is blocked");

    a_result_follows_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_valid && (r_out_channel == $past(r_s1_channel)))
        else $error("result register did not load the updated channel");

endmodule

// ----- bench/phmb_meter_check.sv -----
`timescale 1ns / 1ps
// Meter checker for the peak hold meter bank: watches the request and result
// channels and the register port, predicts each shown level and compares.
// Depends on phmb_pkg, phmb_in_if and phmb_out_if.

module phmb_meter_check import phmb_pkg::*; #(
    parameter int CHANNELS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    phmb_in_if                   i_req,
    phmb_out_if                  i_rsp,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_pending,
    output int                   o_fail_count
);

    typedef struct packed {
        logic [CHANNEL_W-1:0]      channel;
        logic signed [LEVEL_W-1:0] level;
    } t_shown_result;

    logic signed [LEVEL_W-1:0] floor_cfg;
    logic [CFG_W-1:0]          hold_cfg;
    logic [CFG_W-1:0]          rate_cfg;

    logic signed [LEVEL_W-1:0] shown_mem    [CHANNELS];
    logic [TIME_W-1:0]         peak_t_mem   [CHANNELS];
    logic [TIME_W-1:0]         adv_t_mem    [CHANNELS];

    t_shown_result expected_levels [$];
    int            mismatches;

    // Apply one request to the meter copy and return the level it shows.
    function automatic t_shown_result advance_meter(
        input logic                      fn,
        input logic [CHANNEL_W-1:0]      ch,
        input logic signed [LEVEL_W-1:0] peak,
        input logic [TIME_W-1:0]         now
    );
        t_shown_result res;
        longint        level;
        longint        fallen;
        logic [63:0]   hold_end;
        logic [63:0]   fall_start;
        logic [63:0]   drop;
        logic [63:0]   prev_adv;
        res.channel = ch;
        res.level   = floor_cfg;
        if (int'(ch) >= CHANNELS)
            return res;
        level    = shown_mem[ch];
        prev_adv = {32'd0, adv_t_mem[ch]};
        if (longint'(peak) > level) begin
            level         = peak;
            peak_t_mem[ch] = now;
        end
        if (fn) begin
            hold_end   = {32'd0, peak_t_mem[ch]} + {48'd0, hold_cfg};
            fall_start = (prev_adv > hold_end) ? prev_adv : hold_end;
            if ({32'd0, now} > fall_start) begin
                drop = ({48'd0, rate_cfg} * ({32'd0, now} - fall_start)) >> 10;
                if (drop > 64'd200000)
                    drop = 64'd200000;
                fallen = level - longint'(drop);
                if (fallen < longint'(floor_cfg))
                    fallen = floor_cfg;
                level = fallen;
            end
        end
        adv_t_mem[ch] = now;
        shown_mem[ch] = level[LEVEL_W-1:0];
        res.level     = level[LEVEL_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_shown_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                shown_mem[i]  = FLOOR_RESET;
                peak_t_mem[i] = '0;
                adv_t_mem[i]  = '0;
            end
            floor_cfg  = FLOOR_RESET;
            hold_cfg   = HOLD_RESET;
            rate_cfg   = RATE_RESET;
            mismatches = 0;
            expected_levels.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FLOOR_LEVEL: floor_cfg = i_cfg_data;
                    CFG_HOLD_TICKS:  hold_cfg  = i_cfg_data;
                    CFG_FALL_RATE:   rate_cfg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_levels.size() == 0) begin
                    mismatches++;
                    $display("%0t: result ch %0d level %0d with no request waiting",
                             $time, i_rsp.out_channel, $signed(i_rsp.shown_level));
                end else begin
                    want = expected_levels.pop_front();
                    if (i_rsp.out_channel !== want.channel) begin
                        mismatches++;
                        $display("%0t: out_channel expected %0d actual %0d",
                                 $time, want.channel, i_rsp.out_channel);
                    end
                    if (i_rsp.shown_level !== want.level) begin
                        mismatches++;
                        $display("%0t: ch %0d shown_level expected %0d actual %0d",
                                 $time, want.channel, $signed(want.level),
                                 $signed(i_rsp.shown_level));
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                expected_levels.insert(expected_levels.size(),
                                       advance_meter(i_req.func, i_req.channel,
                                                     i_req.peak_level, i_req.now_ticks));
        end
        o_pending    <= expected_levels.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the peak hold meter bank: clock, reset, request stimulus,
// result back-pressure, register settings and the verdict. Depends on
// phmb_pkg, the channel interfaces, phmb_meter_check and the block itself.

module tb;
    import phmb_pkg::*;

    localparam int                   N_CHANNELS   = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;  // index past the register list
    localparam int                   PHASE_ITEMS  = 150;
    localparam int                   PHASES       = 6;
    localparam int                   STALL_AT     = 700;   // results taken before the long stall
    localparam int                   STALL_CYCLES = 60;
    localparam int                   TAIL_CYCLES  = 4;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   pending;
    int                   fail_count;

    int                        send_idle_pct;
    int                        rcv_idle_pct;
    int                        sent_count;
    int                        settings_count;
    logic [TIME_W-1:0]         t_now;
    logic signed [LEVEL_W-1:0] floor_now;
    logic [CHANNEL_W-1:0]      prev_ch;
    logic signed [LEVEL_W-1:0] last_peak [CH_SPAN];

    phmb_in_if  req_if ();
    phmb_out_if rsp_if ();

    peak_hold_meter_bank_top #(
        .CHANNELS (N_CHANNELS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    phmb_meter_check #(
        .CHANNELS (N_CHANNELS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still expected", pending);
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random back-pressure per the current idle mix, plus one
    // long hold-off once enough results have gone by. The hold-off is counted
    // here so the sender keeps offering requests and the block backs up.
    initial begin
        int  taken;
        int  stall_left;
        bit  stalled;
        taken      = 0;
        stall_left = 0;
        stalled    = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                taken++;
            if (stall_left > 0) begin
                stall_left--;
            end else if (!stalled && taken >= STALL_AT) begin
                stall_left = STALL_CYCLES;
                stalled    = 1'b1;
            end
            if (stall_left > 0)
                rsp_if.ready <= 1'b0;
            else
                rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Offer one request after a random gap and hold it until accepted.
    // Valid stays high on return; the next call or drain decides its level.
    task automatic send_request(input logic fn, input logic [CHANNEL_W-1:0] ch,
                                input logic signed [LEVEL_W-1:0] peak,
                                input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= fn;
        req_if.channel    <= ch;
        req_if.peak_level <= peak;
        req_if.now_ticks  <= now;
        do @(posedge clk); while (!req_if.ready);
        sent_count++;
    endtask

    // Drop valid, wait until every result is back, then let the pipe settle.
    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Write all three registers plus the unused index; call only when idle.
    task automatic load_meter_config(input logic signed [LEVEL_W-1:0] floor_v,
                                     input logic [CFG_W-1:0] hold_v,
                                     input logic [CFG_W-1:0] rate_v);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FLOOR_LEVEL;
        cfg_data  <= floor_v;
        @(posedge clk);
        cfg_index <= CFG_HOLD_TICKS;
        cfg_data  <= hold_v;
        @(posedge clk);
        cfg_index <= CFG_FALL_RATE;
        cfg_data  <= rate_v;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        floor_now = floor_v;
        settings_count++;
    endtask

    // Build one random request. Most traffic sits on a few hot channels with
    // time moving forward so holds expire and meters fall; the rest is full
    // range noise, repeated peaks and out-of-order times.
    task automatic random_request();
        logic                      fn;
        logic [CHANNEL_W-1:0]      ch;
        logic signed [LEVEL_W-1:0] peak;
        logic [TIME_W-1:0]         now;
        int                        pick;
        int                        near;
        logic [TIME_W-1:0]         step;
        fn   = ($urandom_range(99) < 70);
        pick = $urandom_range(99);
        if (pick < 15)
            ch = prev_ch;                       // back-to-back hit on one channel
        else if (pick < 75)
            ch = CHANNEL_W'($urandom_range(7));
        else
            ch = CHANNEL_W'($urandom_range(N_CHANNELS - 1));
        pick = $urandom_range(99);
        if (pick < 45) begin
            peak = LEVEL_W'(-int'($urandom_range(9000)));
        end else if (pick < 60) begin
            peak = last_peak[ch];               // equal peak must not restart the hold
        end else if (pick < 75) begin
            peak = LEVEL_W'($urandom);
        end else if (pick < 90) begin
            near = int'(floor_now) + int'($urandom_range(600)) - 300;
            if (near < -32768)
                near = -32768;
            peak = LEVEL_W'(near);
        end else begin
            peak = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end
        pick = $urandom_range(99);
        if (pick < 3) begin
            now = $urandom;                     // stray time, global clock untouched
        end else begin
            if (pick >= 6) begin
                step = TIME_W'($urandom_range(600));
                t_now = (t_now + step < t_now) ? '1 : t_now + step;
            end
            now = t_now;
        end
        last_peak[ch] = peak;
        prev_ch       = ch;
        send_request(fn, ch, peak, now);
    endtask

    initial begin
        int random_idx;
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= CFG_FLOOR_LEVEL;
        cfg_data          <= '0;
        req_if.valid      <= 1'b0;
        req_if.func       <= 1'b0;
        req_if.channel    <= '0;
        req_if.peak_level <= '0;
        req_if.now_ticks  <= '0;
        send_idle_pct     = 31;
        rcv_idle_pct      <= 69;
        sent_count        = 0;
        settings_count    = 0;
        t_now             = '0;
        floor_now         = FLOOR_RESET;
        prev_ch           = '0;
        random_idx        = 0;
        for (int i = 0; i < CH_SPAN; i++)
            last_peak[i] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset registers: -100 dB floor, 1 s hold, 24 dB/s fall.
        send_request(1'b0, 6'd0, 16'sh7FFF, 32'd0);           // loudest peak captured
        send_request(1'b0, 6'd0, 16'sh8000, 32'd5);           // quieter peak ignored
        send_request(1'b1, 6'd0, 16'sh8000, 32'd500);         // still inside the hold
        send_request(1'b1, 6'd0, 16'sh8000, 32'd2048);        // one second of fall
        send_request(1'b1, 6'd0, 16'sd26623, 32'd2048);       // equal peak, no restart
        send_request(1'b1, 6'd0, 16'sh8000, 32'd100);         // time goes backward
        send_request(1'b1, 6'd0, 16'sh8000, 32'd2560);        // fall from hold end
        send_request(1'b1, 6'd63, 16'sh8000, 32'hFFFF_FFFF);  // huge drop clamps at floor
        send_request(1'b0, 6'd1, 16'sd0, 32'hFFFF_FF00);
        send_request(1'b1, 6'd1, 16'sh8000, 32'hFFFF_FFFF);   // hold end past 32 bits
        send_request(1'b1, 6'd2, 16'sh7FFF, 32'd0);
        send_request(1'b1, 6'd2, 16'sh8000, 32'hFFFF_FFFF);
        send_request(1'b1, 6'd3, 16'sh5555, 32'hAAAA_AAAA);
        send_request(1'b1, 6'd42, 16'shAAAA, 32'h5555_5555);
        drain_results();

        // Raise the floor to 0 dB with no hold and the fastest fall.
        load_meter_config(16'sd0, 16'd0, 16'hFFFF);
        send_request(1'b0, 6'd42, 16'sh8000, 32'h5555_5600);  // below floor, observe keeps it
        send_request(1'b1, 6'd42, 16'sh8000, 32'h5555_5600);  // no time passed, kept
        send_request(1'b1, 6'd42, 16'sh8000, 32'h5555_5601);  // fall lifts it to floor
        send_request(1'b1, 6'd3, 16'sh8000, 32'hAAAA_AAAB);
        send_request(1'b0, 6'd10, 16'sh8000, 32'd0);
        send_request(1'b1, 6'd10, 16'sh8000, 32'd5);
        drain_results();

        // Random phases, one register setting each; extremes first.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: load_meter_config(16'sh8000, 16'd0, 16'hFFFF);
                1: load_meter_config(16'sd0, 16'hFFFF, 16'd0);
                2: load_meter_config(LEVEL_W'(-int'($urandom_range(32768))),
                                     CFG_W'($urandom_range(4095)), CFG_W'($urandom));
                3: load_meter_config(FLOOR_RESET, HOLD_RESET, RATE_RESET);
                default: load_meter_config(LEVEL_W'(-int'($urandom_range(32768))),
                                           CFG_W'($urandom), CFG_W'($urandom));
            endcase
            // Run the last phase near the top of the time range.
            if (ph == PHASES - 1)
                t_now = 32'hFFFE_0000;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (random_idx < 300) begin
                    send_idle_pct = 31;
                    rcv_idle_pct  <= 69;
                end else if (random_idx < 600) begin
                    send_idle_pct = 69;
                    rcv_idle_pct  <= 31;
                end else begin
                    send_idle_pct = 0;
                    rcv_idle_pct  <= 0;
                end
                random_request();
                random_idx++;
            end
            drain_results();
        end

        $display("Sent %0d requests over %0d register settings, with idle mixes on both",
                 sent_count, settings_count);
        $display("sides, a long result stall, channel repeats and time jumps.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
